/* sv/sba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants of the slab bitmap block allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

	localparam int CMD_W         = 2;
	localparam int SLAB_IDX_W    = 4;
	localparam int BLOCK_IDX_W   = 6;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 7;

	localparam int NUM_SLABS_DEF  = 16;
	localparam int MAX_BLOCKS_DEF = 64;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
	localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK          = 2'd0,
		STS_NO_SPACE    = 2'd1,
		STS_INVALID     = 2'd2,
		STS_DOUBLE_FREE = 2'd3
	} status_t;

endpackage

/* sv/sba_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_if
// Valid/ready channels of the allocator: command, response and config.
// ----------------------------------------------------------------------------
interface sba_cmd_if import sba_pkg::*; ();
	logic                   valid;
	logic                   ready;
	cmd_t                   command;
	logic [SLAB_IDX_W-1:0]  slab_index;
	logic [BLOCK_IDX_W-1:0] block_index;

	modport source (output valid, command, slab_index, block_index, input ready);
	modport sink   (input valid, command, slab_index, block_index, output ready);
endinterface

interface sba_rsp_if import sba_pkg::*; ();
	logic                   valid;
	logic                   ready;
	status_t                status;
	logic [SLAB_IDX_W-1:0]  out_slab;
	logic [BLOCK_IDX_W-1:0] out_block;
	logic                   owned;

	modport source (output valid, status, out_slab, out_block, owned, input ready);
	modport sink   (input valid, status, out_slab, out_block, owned, output ready);
endinterface

interface sba_cfg_if import sba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] blocks_per_slab;

	modport source (output valid, blocks_per_slab, input ready);
	modport sink   (input valid, blocks_per_slab, output ready);
endinterface

/* sv/sba_ffs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_ffs
// Shared find-first-set unit: lowest set bit by carry isolation, then encode.
// ----------------------------------------------------------------------------
module sba_ffs #(
	parameter int W = 64
) (
	input  logic [W-1:0]         vec,
	output logic                 found,
	output logic [$clog2(W)-1:0] idx
);

	localparam int IW = $clog2(W);

	logic [W-1:0] low;

	always_comb begin
		low   = vec & (~vec + W'(1));
		found = |vec;
		idx   = '0;
		for (int i = 0; i < W; i++) begin
			idx = idx | (low[i] ? IW'(i) : IW'(0));
		end
	end

endmodule

/* sv/sba_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_core
// Command sequencer, slab state vectors and bitmap memory around one shared
// find-first-set unit.
// ----------------------------------------------------------------------------
module sba_core import sba_pkg::*; #(
	parameter int NUM_SLABS  = NUM_SLABS_DEF,
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] count,
	sba_cmd_if.sink            cmd,
	sba_rsp_if.source          rsp
);

	localparam int SW  = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
	localparam int BW  = $clog2(MAX_BLOCKS);
	localparam int FW  = (NUM_SLABS > MAX_BLOCKS) ? NUM_SLABS : MAX_BLOCKS;
	localparam int FIW = $clog2(FW);
	localparam logic [8:0] NUM_SLABS_V = 9'(NUM_SLABS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PICK,
		S_PICK_EMPTY,
		S_SCAN,
		S_NEXT,
		S_CHECK,
		S_FREE,
		S_DONE
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [SLAB_IDX_W-1:0]  slab_in_q;
	logic [BLOCK_IDX_W-1:0] block_q;
	logic [SW-1:0]          slab_q;
	logic [NUM_SLABS-1:0]   partial_q;
	logic [NUM_SLABS-1:0]   full_q;
	logic [MAX_BLOCKS-1:0]  bits_q;
	logic [MAX_BLOCKS-1:0]  rd_q;
	logic [MAX_BLOCKS-1:0]  mem [NUM_SLABS];

	status_t                res_status_q;
	logic [SLAB_IDX_W-1:0]  res_slab_q;
	logic [BLOCK_IDX_W-1:0] res_block_q;
	logic                   res_owned_q;

	logic                   out_valid_q;
	status_t                out_status_q;
	logic [SLAB_IDX_W-1:0]  out_slab_q;
	logic [BLOCK_IDX_W-1:0] out_block_q;
	logic                   out_owned_q;

	logic [MAX_BLOCKS-1:0]  mask;
	logic [NUM_SLABS-1:0]   empty_v;
	logic [SW-1:0]          slab_sel;
	logic [BW-1:0]          blk_sel;
	logic                   in_use;
	logic [FW-1:0]          ffs_vec;
	logic                   ffs_found;
	logic [FIW-1:0]         ffs_idx;
	logic [SW-1:0]          ffs_slab;
	logic [BW-1:0]          ffs_blk;
	logic [MAX_BLOCKS-1:0]  scan_bits;
	logic [MAX_BLOCKS-1:0]  freed;
	logic                   bit_set;
	logic                   cmd_fire;

	logic                   mem_re;
	logic [SW-1:0]          mem_ra;
	logic                   mem_we;
	logic [SW-1:0]          mem_wa;
	logic [MAX_BLOCKS-1:0]  mem_wd;

	sba_ffs #(.W(FW)) u_ffs (
		.vec   (ffs_vec),
		.found (ffs_found),
		.idx   (ffs_idx)
	);

	assign cmd.ready     = (state_q == S_IDLE);
	assign cmd_fire      = cmd.valid && cmd.ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.out_slab  = out_slab_q;
	assign rsp.out_block = out_block_q;
	assign rsp.owned     = out_owned_q;

	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			mask[i] = (COUNT_W'(i) < count);
		end
		empty_v   = ~(partial_q | full_q);
		slab_sel  = SW'(slab_in_q);
		blk_sel   = block_q[BW-1:0];
		in_use    = (9'(slab_in_q) < NUM_SLABS_V) && (COUNT_W'(block_q) < count) &&
			(partial_q[slab_sel] || full_q[slab_sel]);
		ffs_slab  = ffs_idx[SW-1:0];
		ffs_blk   = ffs_idx[BW-1:0];
		scan_bits = rd_q | (MAX_BLOCKS'(1) << ffs_blk);
		freed     = rd_q & ~(MAX_BLOCKS'(1) << blk_sel);
		bit_set   = rd_q[blk_sel];

		case (state_q)
			S_PICK:       ffs_vec = FW'(partial_q);
			S_PICK_EMPTY: ffs_vec = FW'(empty_v);
			S_SCAN:       ffs_vec = FW'(~rd_q & mask);
			S_NEXT:       ffs_vec = FW'(~bits_q & mask);
			default:      ffs_vec = '0;
		endcase

		mem_re = 1'b0;
		mem_ra = slab_sel;
		mem_we = 1'b0;
		mem_wa = slab_q;
		mem_wd = bits_q;
		case (state_q)
			S_PICK: begin
				mem_re = ffs_found;
				mem_ra = ffs_slab;
			end
			S_CHECK: begin
				mem_re = 1'b1;
			end
			S_PICK_EMPTY: begin
				mem_we = ffs_found;
				mem_wa = ffs_slab;
				mem_wd = MAX_BLOCKS'(1);
			end
			S_NEXT: begin
				mem_we = 1'b1;
			end
			S_FREE: begin
				mem_we = bit_set;
				mem_wd = freed;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// bitmap memory, one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			partial_q   <= '0;
			full_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						cmd_q        <= cmd.command;
						slab_in_q    <= cmd.slab_index;
						block_q      <= cmd.block_index;
						res_status_q <= STS_OK;
						res_slab_q   <= '0;
						res_block_q  <= '0;
						res_owned_q  <= 1'b0;
						state_q      <= (cmd.command == CMD_ALLOC) ? S_PICK : S_CHECK;
					end
				end
				S_PICK: begin
					if (ffs_found) begin
						slab_q  <= ffs_slab;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_PICK_EMPTY;
					end
				end
				S_PICK_EMPTY: begin
					if (ffs_found) begin
						partial_q[ffs_slab] <= 1'b1;
						slab_q              <= ffs_slab;
						res_slab_q          <= SLAB_IDX_W'(ffs_slab);
					end else begin
						res_status_q <= STS_NO_SPACE;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (!ffs_found) begin
						// stale count left no clear bit
						partial_q[slab_q] <= 1'b0;
						full_q[slab_q]    <= 1'b1;
						res_status_q      <= STS_NO_SPACE;
						state_q           <= S_DONE;
					end else begin
						bits_q      <= scan_bits;
						res_slab_q  <= SLAB_IDX_W'(slab_q);
						res_block_q <= BLOCK_IDX_W'(ffs_blk);
						state_q     <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (!ffs_found) begin
						partial_q[slab_q] <= 1'b0;
						full_q[slab_q]    <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_CHECK: begin
					slab_q <= slab_sel;
					case (cmd_q)
						CMD_QUERY: begin
							if (in_use) begin
								res_owned_q <= 1'b1;
							end else begin
								res_status_q <= STS_INVALID;
							end
							state_q <= S_DONE;
						end
						CMD_FREE: begin
							if (in_use) begin
								state_q <= S_FREE;
							end else begin
								res_status_q <= STS_INVALID;
								state_q      <= S_DONE;
							end
						end
						default: begin
							res_status_q <= STS_INVALID;
							state_q      <= S_DONE;
						end
					endcase
				end
				S_FREE: begin
					if (!bit_set) begin
						res_status_q <= STS_DOUBLE_FREE;
					end else if (full_q[slab_q]) begin
						full_q[slab_q]    <= 1'b0;
						partial_q[slab_q] <= 1'b1;
					end else if (freed == '0) begin
						partial_q[slab_q] <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slab_q   <= res_slab_q;
						out_block_q  <= res_block_q;
						out_owned_q  <= res_owned_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_state_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(partial_q & full_q) == '0)
		else $error("slab both partial and full");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q != S_IDLE))
		else $error("sequencer idle after accepting a command");

	a_alloc_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && cmd_q == CMD_ALLOC && res_status_q == STS_OK) |->
		(partial_q[slab_q] || full_q[slab_q]))
		else $error("allocated slab not in use");

	a_owned_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_owned_q) |-> (out_status_q == STS_OK))
		else $error("owned flag with error status");

endmodule

/* sv/slab_bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_bitmap_block_allocator
// Block allocator over a fixed pool of slabs with per-slab bitmaps.
// ----------------------------------------------------------------------------
// One command is in flight at a time. States from acceptance to loading the
// result into the output register: allocate from a partial slab PICK, SCAN,
// NEXT, DONE (no NEXT when a stale count leaves the slab full), allocate from
// an empty slab or answer no space PICK, PICK_EMPTY, DONE, free CHECK, FREE,
// DONE (no FREE when rejected), query CHECK, DONE; the next command is taken
// in the cycle after loading. A result waiting in the output register does
// not block acceptance of the next command, but that command holds in its
// last step until the waiting result is taken. The sequencer steps the single
// find-first-set unit (partial slab, empty slab, free bit, next free bit) and
// the one read/one write port of the bitmap memory. The blocks-per-slab
// register is saturated to 8..MAX_BLOCKS and may be written only while idle.
module slab_bitmap_block_allocator import sba_pkg::*; #(
	parameter int NUM_SLABS  = NUM_SLABS_DEF,
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sba_cfg_if.sink   cfg,
	sba_cmd_if.sink   cmd,
	sba_rsp_if.source rsp
);

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_BLOCKS);

	logic [COUNT_W-1:0] blocks_q;
	logic [COUNT_W-1:0] count;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			blocks_q <= cfg.blocks_per_slab;
		end
	end

	always_comb begin
		if (blocks_q < COUNT_MIN) begin
			count = COUNT_MIN;
		end else if (blocks_q > COUNT_MAX) begin
			count = COUNT_MAX;
		end else begin
			count = blocks_q;
		end
	end

	sba_core #(
		.NUM_SLABS  (NUM_SLABS),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.count  (count),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule

/* dv/tb_slab_bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_bitmap_block_allocator
// Self-checking bench for the slab allocator. A directed table walks the
// special cases, then random phases at several blocks-per-slab settings
// fill and drain the pool. An in-bench allocator model, or a typed table
// row, predicts each response; the monitor checks every response against it.
// ----------------------------------------------------------------------------
module tb_slab_bitmap_block_allocator;
	import sba_pkg::*;

	localparam int SLABS        = NUM_SLABS_DEF;
	localparam int BLOCKS       = MAX_BLOCKS_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE       = 8;
	localparam int PHASE_ITEMS  = 180;
	localparam cmd_t CMD_RESERVED = cmd_t'(2'd3);

	typedef enum logic [1:0] {
		SL_EMPTY   = 2'd0,
		SL_PARTIAL = 2'd1,
		SL_FULL    = 2'd2
	} slab_state_t;

	typedef struct packed {
		status_t                status;
		logic [SLAB_IDX_W-1:0]  slab;
		logic [BLOCK_IDX_W-1:0] blk;
		logic                   owned;
	} alloc_rsp_t;

	typedef struct {
		bit                     is_cfg;
		logic [COUNT_W-1:0]     cfg_val;
		cmd_t                   op;
		logic [SLAB_IDX_W-1:0]  slab;
		logic [BLOCK_IDX_W-1:0] blk;
		int                     reps;
		bit                     typed;
		alloc_rsp_t             rsp;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sba_cfg_if cfg_ch ();
	sba_cmd_if cmd_ch ();
	sba_rsp_if rsp_ch ();

	slab_bitmap_block_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// allocator model state
	logic [BLOCKS-1:0]  occ_map    [SLABS];
	logic [COUNT_W-1:0] lo_free    [SLABS];
	slab_state_t        slab_st    [SLABS];
	logic [COUNT_W-1:0] blocks_reg;

	alloc_rsp_t pending_rsp [$];
	int         errors;
	int         quiet_cycles;
	bit         row_typed;
	alloc_rsp_t row_rsp;
	int         long_hold_req;
	int         long_hold_done;
	int         n_alloc, n_free, n_query, n_other, n_cfg;
	int         n_no_space, n_double, n_invalid, n_owned;

	step_row_t dir_rows [15] = '{
		'{1'b0, 7'd0, CMD_QUERY,    4'd0,  6'd0,  1, 1'b1, '{STS_INVALID, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_FREE,     4'd0,  6'd0,  1, 1'b1, '{STS_INVALID, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_RESERVED, 4'd15, 6'd63, 1, 1'b1, '{STS_INVALID, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_ALLOC,    4'd0,  6'd0,  1, 1'b1, '{STS_OK, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_QUERY,    4'd0,  6'd63, 1, 1'b1, '{STS_OK, 4'd0, 6'd0, 1'b1}},
		'{1'b0, 7'd0, CMD_FREE,     4'd0,  6'd5,  1, 1'b1, '{STS_DOUBLE_FREE, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_ALLOC,    4'd0,  6'd0,  8, 1'b0, '{STS_OK, 4'd0, 6'd0, 1'b0}},
		'{1'b1, 7'd8, CMD_ALLOC,    4'd0,  6'd0,  0, 1'b0, '{STS_OK, 4'd0, 6'd0, 1'b0}},
		// stale first-free after shrinking: slab 0 goes full, no space
		'{1'b0, 7'd0, CMD_ALLOC,    4'd0,  6'd0,  1, 1'b1, '{STS_NO_SPACE, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_ALLOC,    4'd0,  6'd0,  1, 1'b1, '{STS_OK, 4'd1, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_QUERY,    4'd0,  6'd8,  1, 1'b1, '{STS_INVALID, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_FREE,     4'd0,  6'd3,  1, 1'b1, '{STS_OK, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_ALLOC,    4'd0,  6'd0,  1, 1'b0, '{STS_OK, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_FREE,     4'd1,  6'd0,  1, 1'b1, '{STS_OK, 4'd0, 6'd0, 1'b0}},
		'{1'b0, 7'd0, CMD_QUERY,    4'd1,  6'd0,  1, 1'b1, '{STS_INVALID, 4'd0, 6'd0, 1'b0}}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// allocator model
	// ------------------------------------------------------------------------
	function automatic int unsigned usable_blocks();
		int unsigned c;
		c = 32'(blocks_reg);
		if (c < COUNT_MIN) c = 32'(COUNT_MIN);
		if (c > BLOCKS) c = BLOCKS;
		return c;
	endfunction

	function automatic int unsigned lowest_free(logic [BLOCKS-1:0] bits, int unsigned cnt);
		for (int unsigned b = 0; b < cnt; b++) begin
			if (!bits[b]) return b;
		end
		return cnt;
	endfunction

	function automatic alloc_rsp_t model_alloc(int unsigned cnt);
		alloc_rsp_t r;
		int unsigned pos;
		int unsigned nf;
		r = '{STS_OK, '0, '0, 1'b0};
		for (int s = 0; s < SLABS; s++) begin
			if (slab_st[s] == SL_PARTIAL) begin
				pos = 32'(lo_free[s]);
				if (pos >= cnt || occ_map[s][pos])
					pos = lowest_free(occ_map[s], cnt);
				if (pos >= cnt) begin
					slab_st[s] = SL_FULL;
					lo_free[s] = COUNT_W'(cnt);
					r.status   = STS_NO_SPACE;
					return r;
				end
				occ_map[s][pos] = 1'b1;
				nf = lowest_free(occ_map[s], cnt);
				lo_free[s] = COUNT_W'(nf);
				if (nf >= cnt) slab_st[s] = SL_FULL;
				r.slab = SLAB_IDX_W'(s);
				r.blk  = BLOCK_IDX_W'(pos);
				return r;
			end
		end
		for (int s = 0; s < SLABS; s++) begin
			if (slab_st[s] == SL_EMPTY) begin
				occ_map[s] = BLOCKS'(1);
				lo_free[s] = 7'd1;
				slab_st[s] = SL_PARTIAL;
				r.slab     = SLAB_IDX_W'(s);
				return r;
			end
		end
		r.status = STS_NO_SPACE;
		return r;
	endfunction

	function automatic alloc_rsp_t model_command(cmd_t op, int unsigned s, int unsigned b);
		alloc_rsp_t r;
		int unsigned cnt;
		bit in_use;
		r = '{STS_OK, '0, '0, 1'b0};
		cnt = usable_blocks();
		if (op == CMD_ALLOC) return model_alloc(cnt);
		in_use = s < SLABS && b < cnt && slab_st[s] != SL_EMPTY;
		if (op == CMD_QUERY) begin
			if (in_use) r.owned = 1'b1;
			else r.status = STS_INVALID;
			return r;
		end
		if (op != CMD_FREE || !in_use) begin
			r.status = STS_INVALID;
			return r;
		end
		if (!occ_map[s][b]) begin
			r.status = STS_DOUBLE_FREE;
			return r;
		end
		occ_map[s][b] = 1'b0;
		if (b < lo_free[s]) lo_free[s] = COUNT_W'(b);
		if (slab_st[s] == SL_FULL) slab_st[s] = SL_PARTIAL;
		else if (occ_map[s] == '0) slab_st[s] = SL_EMPTY;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// monitor and checker
	// ------------------------------------------------------------------------
	task automatic field_check(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		alloc_rsp_t got;
		alloc_rsp_t want;
		if (!arst_n) begin
			errors     = 0;
			blocks_reg = COUNT_RESET;
			for (int s = 0; s < SLABS; s++) begin
				occ_map[s] = '0;
				lo_free[s] = '0;
				slab_st[s] = SL_EMPTY;
			end
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.status, rsp_ch.out_slab, rsp_ch.out_block, rsp_ch.owned};
				if (pending_rsp.size() == 0) begin
					errors++;
					$display("%0t ns: response with none expected, actual %p", $time, got);
				end else begin
					want = pending_rsp.pop_front();
					field_check("status", 32'(want.status), 32'(got.status));
					field_check("out_slab", 32'(want.slab), 32'(got.slab));
					field_check("out_block", 32'(want.blk), 32'(got.blk));
					field_check("owned", 32'(want.owned), 32'(got.owned));
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				blocks_reg = cfg_ch.blocks_per_slab;
				n_cfg++;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = model_command(cmd_ch.command, 32'(cmd_ch.slab_index),
				                     32'(cmd_ch.block_index));
				if (row_typed) want = row_rsp;
				pending_rsp.push_back(want);
				case (cmd_ch.command)
					CMD_ALLOC: n_alloc++;
					CMD_FREE:  n_free++;
					CMD_QUERY: n_query++;
					default:   n_other++;
				endcase
				case (want.status)
					STS_NO_SPACE:    n_no_space++;
					STS_DOUBLE_FREE: n_double++;
					STS_INVALID:     n_invalid++;
					default:         if (want.owned) n_owned++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: timeout, %0d responses outstanding", $time, pending_rsp.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// response side: stall patterns plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int mode;
		int len;
		int per;
		rsp_ch.ready   = 1'b0;
		long_hold_done = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(10, 80);
			per  = $urandom_range(2, 5);
			for (int i = 0; i < len; i++) begin
				@(negedge clk);
				if (long_hold_req != long_hold_done) begin
					rsp_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					long_hold_done = long_hold_req;
				end else begin
					case (mode)
						0:       rsp_ch.ready <= 1'b1;
						1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
						2:       rsp_ch.ready <= (i % per) != 0;
						default: rsp_ch.ready <= $urandom_range(0, 7) != 0;
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------------
	task automatic send_cmd(cmd_t op, logic [SLAB_IDX_W-1:0] s, logic [BLOCK_IDX_W-1:0] b,
	                        bit typed, alloc_rsp_t r);
		@(negedge clk);
		cmd_ch.valid       <= 1'b1;
		cmd_ch.command     <= op;
		cmd_ch.slab_index  <= s;
		cmd_ch.block_index <= b;
		row_typed = typed;
		row_rsp   = r;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic idle_cmd(int n);
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		idle_cmd(1);
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic write_blocks(logic [COUNT_W-1:0] v);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.blocks_per_slab <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic bit pick_used_block(output logic [SLAB_IDX_W-1:0] s,
	                                       output logic [BLOCK_IDX_W-1:0] b);
		int unsigned s0;
		int unsigned b0;
		int unsigned si;
		int unsigned bj;
		s0 = $urandom_range(0, SLABS - 1);
		b0 = $urandom_range(0, BLOCKS - 1);
		s = '0;
		b = '0;
		for (int i = 0; i < SLABS; i++) begin
			si = (s0 + i) % SLABS;
			if (slab_st[si] != SL_EMPTY && occ_map[si] != '0) begin
				for (int j = 0; j < BLOCKS; j++) begin
					bj = (b0 + j) % BLOCKS;
					if (occ_map[si][bj]) begin
						s = SLAB_IDX_W'(si);
						b = BLOCK_IDX_W'(bj);
						return 1'b1;
					end
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic run_phase(logic [COUNT_W-1:0] setting, bit gappy, int hold_at, int pause_at);
		int burst;
		int roll;
		int alloc_w;
		int free_w;
		cmd_t op;
		logic [SLAB_IDX_W-1:0] s;
		logic [BLOCK_IDX_W-1:0] b;
		write_blocks(setting);
		burst = $urandom_range(1, 20);
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if (k == hold_at) long_hold_req++;
			if (k == pause_at) wait_drained();
			// first part of a phase fills the pool, the rest drains it
			alloc_w = (k < PHASE_ITEMS * 7 / 10) ? 80 : 15;
			free_w  = (k < PHASE_ITEMS * 7 / 10) ? 8 : 55;
			roll = $urandom_range(0, 99);
			s = SLAB_IDX_W'($urandom_range(0, SLABS - 1));
			b = BLOCK_IDX_W'($urandom_range(0, BLOCKS - 1));
			if (roll < alloc_w) begin
				op = CMD_ALLOC;
			end else if (roll < alloc_w + free_w) begin
				op = CMD_FREE;
				void'(pick_used_block(s, b));
			end else if (roll < alloc_w + free_w + 6) begin
				op = CMD_FREE;
			end else if (roll < alloc_w + free_w + 7) begin
				op = CMD_RESERVED;
			end else begin
				op = CMD_QUERY;
				if ($urandom_range(0, 1)) void'(pick_used_block(s, b));
			end
			send_cmd(op, s, b, 1'b0, '0);
			if (gappy) begin
				burst--;
				if (burst == 0) begin
					idle_cmd($urandom_range(1, 8));
					burst = $urandom_range(1, 20);
				end
			end
		end
	endtask

	initial begin
		logic [COUNT_W-1:0] settings [8];
		arst_n                 = 1'b0;
		cmd_ch.valid           = 1'b0;
		cmd_ch.command         = CMD_ALLOC;
		cmd_ch.slab_index      = '0;
		cmd_ch.block_index     = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.blocks_per_slab = '0;
		row_typed              = 1'b0;
		row_rsp                = '0;
		long_hold_req          = 0;
		settings = '{7'd64, 7'd8, 7'd127, 7'd0, 7'd20, 7'd7, 7'd65, 7'd0};
		settings[7] = COUNT_W'($urandom_range(0, 127));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_blocks(dir_rows[i].cfg_val);
			end else begin
				for (int r = 0; r < dir_rows[i].reps; r++)
					send_cmd(dir_rows[i].op, dir_rows[i].slab, dir_rows[i].blk,
					         dir_rows[i].typed, dir_rows[i].rsp);
			end
		end

		foreach (settings[p])
			run_phase(settings[p], (p % 3) != 2, (p == 1) ? 40 : -1, (p == 3) ? 90 : -1);

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Ran %0d allocs, %0d frees, %0d queries, %0d reserved ops over %0d settings",
		         n_alloc, n_free, n_query, n_other, n_cfg);
		$display("Saw %0d no-space, %0d double-free, %0d invalid, %0d owned answers",
		         n_no_space, n_double, n_invalid, n_owned);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
sv/sba_pkg.sv
sv/sba_if.sv
sv/sba_ffs.sv
sv/sba_core.sv
sv/slab_bitmap_block_allocator.sv
dv/tb_slab_bitmap_block_allocator.sv
